>>> src/spn_pkg.sv
// Shared types and constants for the segment-to-polar-normal block.
// No dependencies; used by spn_stage and segment_to_polar_normal.
`timescale 1ns / 1ps

package spn_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 16;
  localparam int ACC_BITS        = 30;
  localparam int SQRT_STAGES     = 17;   // one root bit per stage
  localparam int RHO_STAGES      = 16;   // one rho bit per stage
  localparam int ATAN_DEPTH      = 24;

  localparam longint PI_ACC      = 64'd3373259426;
  localparam longint HALF_PI_ACC = 64'd1686629713;

  // atan(2^-i), Q30, truncated
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
    32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // One word in flight through the iterative stages.
  typedef struct packed {
    logic               valid;
    logic               deg;     // endpoints coincide
    logic               cz;      // line through origin
    logic [33:0]        n;       // a^2 + b^2
    logic [16:0]        root;    // sqrt(n) so far
    logic [18:0]        rem;     // sqrt remainder
    logic [67:0]        s;       // c^2 - r^2 * n
    logic [49:0]        p;       // r * n
    logic [15:0]        r;       // rho so far
    logic signed [49:0] x;
    logic signed [49:0] y;
    logic signed [33:0] z;       // Q30 angle
  } spn_work_t;

endpackage

>>> src/spn_stage.sv
// One iteration stage: a square-root digit, a rho bit and a CORDIC rotation.
// Depends on spn_pkg.
`timescale 1ns / 1ps

module spn_stage #(
  parameter int STAGE         = 0,
  parameter int CORDIC_STAGES = spn_pkg::CORDIC_STAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  spn_pkg::spn_work_t d,
  output spn_pkg::spn_work_t q
);

  localparam bit DO_SQRT = STAGE < spn_pkg::SQRT_STAGES;
  localparam bit DO_RHO  = STAGE < spn_pkg::RHO_STAGES;
  localparam bit DO_ROT  = STAGE < CORDIC_STAGES;
  localparam int SB = DO_SQRT ? spn_pkg::SQRT_STAGES - 1 - STAGE : 0;
  localparam int RB = DO_RHO ? spn_pkg::RHO_STAGES - 1 - STAGE : 0;
  localparam int CI = DO_ROT ? STAGE : 0;

  spn_pkg::spn_work_t q_next;
  logic [20:0]        trial;
  logic [20:0]        sub;
  logic [67:0]        delta;
  logic signed [49:0] dx;
  logic signed [49:0] dy;
  logic signed [33:0] da;

  always_comb begin
    q_next = d;
    trial  = {d.rem, d.n[2*SB+1 -: 2]};
    sub    = {2'b00, d.root, 2'b01};
    delta  = (({18'b0, d.p}) << (RB + 1)) + (({34'b0, d.n}) << (2 * RB));
    dx     = d.y >>> CI;
    dy     = d.x >>> CI;
    da     = 34'(spn_pkg::ATAN_TAB[CI]);
    if (DO_SQRT) begin
      if (trial >= sub) begin
        q_next.rem  = 19'(trial - sub);
        q_next.root = {d.root[15:0], 1'b1};
      end else begin
        q_next.rem  = trial[18:0];
        q_next.root = {d.root[15:0], 1'b0};
      end
    end
    if (DO_RHO && (delta <= d.s)) begin
      q_next.s     = d.s - delta;
      q_next.p     = d.p + (({16'b0, d.n}) << RB);
      q_next.r[RB] = 1'b1;
    end
    if (DO_ROT) begin
      if (d.y > 0) begin
        q_next.x = d.x + dx;
        q_next.y = d.y - dy;
        q_next.z = d.z + da;
      end else if (d.y < 0) begin
        q_next.x = d.x - dx;
        q_next.y = d.y + dy;
        q_next.z = d.z - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

>>> src/segment_to_polar_normal.sv
// Top level: segment endpoints in, Hesse normal form and length out.
// Depends on spn_pkg and spn_stage.
`timescale 1ns / 1ps

// Streams one segment word per cycle while the output is not held. It has
// three setup stages (differences and cross products, squares,
// then n = a^2 + b^2, c^2 and quadrant fold), one chain of iteration
// stages that runs the square-root digit recurrence, the bit-by-bit rho
// search and the CORDIC vectoring side by side, and one output stage that
// rounds and clamps the angle. The chain length is set by the 17-bit root
// or by CORDIC_STAGES, whichever is larger. The whole pipe holds while a
// finished result waits on line_ready; empty slots hold in place as well.
// Coinciding endpoints give degenerate = 1 and zeros; a line through the
// origin gives rho = 0 and theta = 0.
module segment_to_polar_normal #(
  parameter int ANGLE_FRAC_BITS = spn_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = spn_pkg::CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  output logic               seg_ready,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  output logic               line_valid,
  input  logic               line_ready,
  output logic [15:0]        normal_distance,
  output logic signed [15:0] normal_angle,
  output logic [16:0]        segment_length,
  output logic               degenerate
);

  localparam int DEPTH = (CORDIC_STAGES > spn_pkg::SQRT_STAGES) ?
                         CORDIC_STAGES : spn_pkg::SQRT_STAGES;
  localparam int SH = spn_pkg::ACC_BITS - ANGLE_FRAC_BITS;
  localparam longint PI_Q_L = (spn_pkg::PI_ACC + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam logic signed [34:0] PI_Q = 35'(PI_Q_L);

  // whole pipe moves unless the output word is held
  logic adv;
  assign adv       = !line_valid || line_ready;
  assign seg_ready = adv;

  // stage 1: differences and cross products
  logic               v1;
  logic signed [16:0] a1, b1;
  logic signed [31:0] p1, p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= 17'(first_y) - 17'(second_y);
      b1 <= 17'(second_x) - 17'(first_x);
      p1 <= 32'(first_x) * 32'(second_y);
      p2 <= 32'(second_x) * 32'(first_y);
    end
  end

  // stage 2: squares, c, |c|, direction of the foot point
  logic               v2;
  logic [31:0]        a2, b2;
  logic [31:0]        cm2;
  logic               cz2;
  logic signed [17:0] vx2, vy2;
  logic signed [32:0] c_w;
  logic signed [33:0] asq, bsq;

  assign c_w = 33'(p1) - 33'(p2);
  assign asq = 34'(a1) * 34'(a1);
  assign bsq = 34'(b1) * 34'(b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2  <= asq[31:0];
      b2  <= bsq[31:0];
      cm2 <= c_w[32] ? 32'(-c_w) : c_w[31:0];
      cz2 <= (c_w == '0);
      if (c_w > 0) begin
        vx2 <= -18'(a1);
        vy2 <= -18'(b1);
      end else begin
        vx2 <= 18'(a1);
        vy2 <= 18'(b1);
      end
    end
  end

  // stage 3: n, c^2 and quadrant fold into the first chain word
  spn_pkg::spn_work_t w0_next;
  logic signed [17:0] fx, fy;
  logic signed [33:0] fz;
  logic [33:0]        n_w;

  assign n_w = 34'(a2) + 34'(b2);

  always_comb begin
    fx = vx2;
    fy = vy2;
    fz = '0;
    if (vx2 < 0) begin
      if (vy2 >= 0) begin
        fx = vy2;
        fy = -vx2;
        fz = 34'(spn_pkg::HALF_PI_ACC);
      end else begin
        fx = -vy2;
        fy = vx2;
        fz = -34'(spn_pkg::HALF_PI_ACC);
      end
    end
    w0_next       = '0;
    w0_next.valid = v2;
    w0_next.deg   = (n_w == '0);
    w0_next.cz    = cz2;
    w0_next.n     = n_w;
    w0_next.s     = {4'b0, 64'(cm2) * 64'(cm2)};
    w0_next.x     = 50'(fx) <<< spn_pkg::ACC_BITS;
    w0_next.y     = 50'(fy) <<< spn_pkg::ACC_BITS;
    w0_next.z     = fz;
  end

  spn_pkg::spn_work_t chain [DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0] <= w0_next;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_stage
    spn_stage #(
      .STAGE         (g),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  // output stage: round the angle, clamp to pi, saturate to 16 bits
  spn_pkg::spn_work_t wl;
  logic signed [34:0] zr;
  logic signed [34:0] qa;
  logic signed [15:0] ang;

  assign wl = chain[DEPTH];
  assign zr = (35'(wl.z) + (35'sd1 <<< (SH - 1))) >>> SH;

  always_comb begin
    qa = zr;
    if (qa > PI_Q) begin
      qa = PI_Q;
    end
    if (qa < -PI_Q) begin
      qa = -PI_Q;
    end
    if (qa > 35'sd32767) begin
      ang = 16'sh7fff;
    end else if (qa < -35'sd32768) begin
      ang = -16'sh8000;
    end else begin
      ang = qa[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else if (adv) begin
      line_valid <= wl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= wl.deg;
      if (wl.deg) begin
        normal_distance <= '0;
        normal_angle    <= '0;
        segment_length  <= '0;
      end else begin
        segment_length  <= wl.root;
        normal_distance <= wl.cz ? 16'd0 : wl.r;
        normal_angle    <= wl.cz ? 16'sd0 : ang;
      end
    end
  end

  // a degenerate word carries only zeros
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    line_valid && degenerate |->
      normal_distance == 0 && normal_angle == 0 && segment_length == 0)
    else $error("degenerate word with nonzero results");

  // distinct endpoints always have a length of at least one lsb
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_valid && !degenerate |-> segment_length != 0)
    else $error("zero length on a proper segment");

  // angle never passes the rounded pi
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> 35'(normal_angle) <= PI_Q && 35'(normal_angle) >= -PI_Q)
    else $error("angle beyond pi");

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !line_valid && !chain[0].valid)
    else $error("valid word after reset");

endmodule
